// ===== rtl/shared_buffer_multi_queue_core_macros.svh =====
// Assertion macros used by the checker file of the multi-queue core.
`ifndef SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SBMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SBMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbmq_pkg.sv =====
// Package with the types and codes of the shared-buffer multi-queue core.
`timescale 1ns / 1ps
package sbmq_pkg;

  localparam int DATA_IO_W = 32;
  localparam int QSEL_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [DATA_IO_W-1:0] DATA_EMPTY = '1;
  localparam logic [DATA_IO_W-1:0] DATA_NONE  = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRD,
    S_LNK
  } state_t;

endpackage

// ===== rtl/shared_buffer_multi_queue_core.sv =====
// Top level: several FIFO queues sharing one linked entry store with a free list.
`timescale 1ns / 1ps
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+------------------------------
// input    | in_opcode, in_queue_select, in_data_in       | taken when start & !busy
// result   | out_status, out_data_out                     | out_valid strobe, one cycle
//
// Each item runs through the queue table read (registered memory), then the entry
// link/data read (registered memory), then the write-back and the result register.
// The result strobe shows in the cycle after the write-back, when busy is already low,
// so the next item may be taken in that same cycle; no item is taken while busy.
// Reset (rst_n, synchronous) needs no clearing pass.
// The receiver cannot stall: every item yields exactly one result strobe.
module shared_buffer_multi_queue_core #(
  parameter int NUM_ENTRIES = 16,
  parameter int NUM_QUEUES  = 4,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_opcode,
  input  logic [sbmq_pkg::QSEL_W-1:0]            in_queue_select,
  input  logic signed [sbmq_pkg::DATA_IO_W-1:0]  in_data_in,
  output logic                                   out_valid,
  output logic [sbmq_pkg::STATUS_W-1:0]          out_status,
  output logic signed [sbmq_pkg::DATA_IO_W-1:0]  out_data_out
);
  import sbmq_pkg::*;

  // Pointer codes run 0..NUM_ENTRIES-1; the code NUM_ENTRIES means null.
  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int PW = $clog2(NUM_ENTRIES + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] NULL_P = PW'(NUM_ENTRIES);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } qent_t;

  // Storage: queue table, entry links, entry data.
  qent_t                 qmem     [NUM_QUEUES];
  logic [PW-1:0]         link_mem [NUM_ENTRIES];
  logic [DATA_WIDTH-1:0] data_mem [NUM_ENTRIES];

  // Control state.
  state_t                state_r, state_nxt;
  logic [NUM_QUEUES-1:0] qvalid_r, qvalid_nxt;
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         fill_r, fill_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item and read-back registers.
  logic                  op_r;
  logic [QSEL_W-1:0]     qsel_r;
  logic [DATA_IO_W-1:0]  data_r;
  logic                  qok_r;
  logic                  qvld_r;
  qent_t                 qrd_r;
  logic [PW-1:0]         ent_addr_r;
  logic [PW-1:0]         link_rd_r;
  logic [DATA_WIDTH-1:0] data_rd_r;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [DATA_IO_W-1:0]  out_data_r, out_data_nxt;

  // Memory write controls.
  logic                  q_we;
  qent_t                 q_wdata;
  logic                  lnk_we;
  logic [PW-1:0]         lnk_waddr;
  logic [PW-1:0]         lnk_wdata;
  logic                  dat_we;

  logic                  accept;
  logic [QW-1:0]         q_idx_in;
  logic [QW-1:0]         q_idx;
  logic [PW-1:0]         head_cur;
  logic [PW-1:0]         tail_cur;
  logic                  head_ok;
  logic                  tail_ok;
  logic                  fh_ok;
  logic [PW-1:0]         ent_addr;
  logic [PW-1:0]         link_val;
  logic [PW-1:0]         deq_next;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_IO_W-1:0]  deq_val;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign q_idx_in = QW'(in_queue_select);
  assign q_idx    = QW'(qsel_r);

  // The queue entry reads as empty until that queue is first written.
  assign head_cur = qvld_r ? qrd_r.head : NULL_P;
  assign tail_cur = qvld_r ? qrd_r.tail : NULL_P;
  assign head_ok  = (head_cur < NULL_P);
  assign tail_ok  = (tail_cur < NULL_P);
  assign fh_ok    = (free_head_r < NULL_P);

  // Dequeue follows the queue head, enqueue the free-list head.
  assign ent_addr = (op_r == OP_DEQ) ? head_cur : free_head_r;

  // Entries at or beyond the fill mark were never written and still chain to the next one.
  assign link_val = (ent_addr_r >= fill_r) ? (ent_addr_r + PW'(1)) : link_rd_r;
  // The tail's link is never kept up to date; the tail itself ends the queue.
  assign deq_next = (ent_addr_r == tail_cur) ? NULL_P : link_val;

  assign wr_data = DATA_WIDTH'(data_r);

  // Sign-extend narrow data; wide data keeps its low output bits.
  generate
    if (DATA_WIDTH >= DATA_IO_W) begin : g_wide
      assign deq_val = data_rd_r[DATA_IO_W-1:0];
    end else begin : g_narrow
      assign deq_val = DATA_IO_W'(signed'(data_rd_r));
    end
  endgenerate

  // Next state, memory writes and the result.
  always_comb begin
    state_nxt      = state_r;
    qvalid_nxt     = qvalid_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    q_we           = 1'b0;
    q_wdata        = qrd_r;
    lnk_we         = 1'b0;
    lnk_waddr      = ent_addr_r;
    lnk_wdata      = NULL_P;
    dat_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_QRD;
        end
      end
      S_QRD: begin
        state_nxt = S_LNK;
      end
      S_LNK: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (op_r == OP_ENQ) begin
          out_data_nxt = DATA_NONE;
          if (qok_r && fh_ok) begin
            // Pop the free list, append the entry after the tail.
            out_status_nxt = ST_DONE;
            free_head_nxt  = link_val;
            if (ent_addr_r >= fill_r) begin
              fill_nxt = fill_r + PW'(1);
            end
            dat_we         = 1'b1;
            q_we           = 1'b1;
            qvalid_nxt[q_idx] = 1'b1;
            q_wdata.tail   = ent_addr_r;
            if (head_ok && tail_ok) begin
              q_wdata.head = head_cur;
              lnk_we       = 1'b1;
              lnk_waddr    = tail_cur;
              lnk_wdata    = ent_addr_r;
            end else begin
              q_wdata.head = ent_addr_r;
            end
          end else begin
            out_status_nxt = ST_FULL;
          end
        end else begin
          if (qok_r && head_ok) begin
            // Unlink the head and push it on the front of the free list.
            out_status_nxt    = ST_DONE;
            out_data_nxt      = deq_val;
            q_we              = 1'b1;
            qvalid_nxt[q_idx] = 1'b1;
            if (deq_next < NULL_P) begin
              q_wdata.head = deq_next;
              q_wdata.tail = tail_cur;
            end else begin
              q_wdata.head = NULL_P;
              q_wdata.tail = NULL_P;
            end
            lnk_we        = 1'b1;
            lnk_waddr     = ent_addr_r;
            lnk_wdata     = fh_ok ? free_head_r : NULL_P;
            free_head_nxt = ent_addr_r;
          end else begin
            out_status_nxt = ST_EMPTY;
            out_data_nxt   = DATA_EMPTY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qvalid_r    <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qvalid_r    <= qvalid_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the item, capture the queue-table read on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      qsel_r <= in_queue_select;
      data_r <= in_data_in;
      qok_r  <= (32'(in_queue_select) < NUM_QUEUES);
      qvld_r <= qvalid_r[q_idx_in];
      qrd_r  <= qmem[q_idx_in];
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Queue table write port.
  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_idx] <= q_wdata;
    end
  end

  // Entry stores: read in the queue-read cycle, written at the end of the item.
  always_ff @(posedge clk) begin
    if (state_r == S_QRD) begin
      ent_addr_r <= ent_addr;
      link_rd_r  <= link_mem[ent_addr[IW-1:0]];
      data_rd_r  <= data_mem[ent_addr[IW-1:0]];
    end
    if (lnk_we) begin
      link_mem[lnk_waddr[IW-1:0]] <= lnk_wdata;
    end
    if (dat_we) begin
      data_mem[ent_addr_r[IW-1:0]] <= wr_data;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;

endmodule

// ===== rtl/sbmq_checker.sv =====
// Port-level checker for the multi-queue core, bound to the top level.
`timescale 1ns / 1ps
`include "shared_buffer_multi_queue_core_macros.svh"
module sbmq_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic [sbmq_pkg::STATUS_W-1:0]         out_status,
  input logic signed [sbmq_pkg::DATA_IO_W-1:0] out_data_out
);
  import sbmq_pkg::*;

  `SBMQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `SBMQ_ASSERT_IMP(a_result_lat, start && !busy, ##3 out_valid, "result not three cycles on")
  `SBMQ_ASSERT_NXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `SBMQ_ASSERT_IMP(a_empty_data, out_valid && out_status == ST_EMPTY,
                   out_data_out == DATA_EMPTY, "empty result without all-ones data")
  `SBMQ_ASSERT_IMP(a_full_data, out_valid && out_status == ST_FULL,
                   out_data_out == DATA_NONE, "full result with nonzero data")

endmodule

bind shared_buffer_multi_queue_core sbmq_checker u_sbmq_checker (.*);
